### rtl/core/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// shared types, constants and controller/datapath command and status structs
// for the counting semaphore with wait queue
// ----------------------------------------------------------------------------
package csf_pkg;

	localparam int WAIT_DEPTH = 256;
	localparam int PTR_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);
	localparam int COUNT_W    = 16;
	localparam int TID_W      = 8;
	localparam int WAIT_W     = 9;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(WAIT_DEPTH - 1);
	localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(WAIT_DEPTH);

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic REG_INITIAL_COUNT = 1'b0;

	typedef enum logic [2:0] {
		OUT_IGNORED     = 3'd0,
		OUT_ACQUIRED    = 3'd1,
		OUT_BLOCKED     = 3'd2,
		OUT_WOKE        = 3'd3,
		OUT_INCREMENTED = 3'd4,
		OUT_QUEUE_FULL  = 3'd5,
		OUT_SATURATED   = 3'd6
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT
	} ctrl_state_t;

	typedef struct packed {
		logic load_item;
		logic commit;
		logic rd_issue;
		logic wake_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_wake;
	} dp_status_t;

	typedef struct packed {
		logic               wr;
		logic [COUNT_W-1:0] data;
	} cfg_wr_t;

endpackage

### rtl/core/csf_if.sv
// ----------------------------------------------------------------------------
// csf channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface csf_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] thread_id;
	logic       in_thread_mode;

	modport source (output valid, command, thread_id, in_thread_mode, input ready);
	modport sink   (input valid, command, thread_id, in_thread_mode, output ready);
endinterface

interface csf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  outcome;
	logic [7:0]  affected_thread;
	logic        switch_request;
	logic [15:0] count_now;
	logic [8:0]  waiting_now;

	modport source (output valid, outcome, affected_thread, switch_request, count_now,
		waiting_now, input ready);
	modport sink   (input valid, outcome, affected_thread, switch_request, count_now,
		waiting_now, output ready);
endinterface

### rtl/core/csf_ctrl.sv
// ----------------------------------------------------------------------------
// csf_ctrl
// sequencer: takes one item, runs the update, waits on the queue read for a
// wake-up, and owns the result valid flag
// ----------------------------------------------------------------------------
module csf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  csf_pkg::dp_status_t status,
	output csf_pkg::dp_cmd_t    cmd
);
	import csf_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit || cmd.wake_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_wake) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_RDWAIT;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_RDWAIT: begin
				if (slot_free) begin
					cmd.wake_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/core/csf_datapath.sv
// ----------------------------------------------------------------------------
// csf_datapath
// permit counter, wait queue pointers and store, item and result registers
// ----------------------------------------------------------------------------
module csf_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csf_pkg::dp_cmd_t          cmd,
	output csf_pkg::dp_status_t       status,
	input  csf_pkg::cfg_wr_t          cfg,
	output logic [csf_pkg::COUNT_W-1:0] init_count,
	input  logic                      item_command,
	input  logic [csf_pkg::TID_W-1:0] item_thread_id,
	input  logic                      item_thread_mode,
	output csf_pkg::outcome_t         outcome,
	output logic [csf_pkg::TID_W-1:0] affected_thread,
	output logic                      switch_request,
	output logic [csf_pkg::COUNT_W-1:0] count_now,
	output logic [csf_pkg::WAIT_W-1:0] waiting_now
);
	import csf_pkg::*;

	logic [TID_W-1:0]   store_mem [WAIT_DEPTH];
	logic [TID_W-1:0]   rdata_q;

	logic [COUNT_W-1:0] init_q;
	logic [COUNT_W-1:0] counter_q, counter_d;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [FILL_W-1:0]  fill_q, fill_d;

	logic               cmd_q;
	logic [TID_W-1:0]   tid_q;
	logic               mode_q;

	outcome_t           res_d;
	logic               push;

	outcome_t           outcome_q;
	logic [TID_W-1:0]   affected_q;
	logic               switch_q;
	logic [COUNT_W-1:0] count_q;
	logic [WAIT_W-1:0]  waiting_q;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	assign status.is_wake = mode_q && (cmd_q == CMD_RELEASE) && (fill_q != '0);

	always_comb begin
		res_d     = OUT_IGNORED;
		counter_d = counter_q;
		fill_d    = fill_q;
		push      = 1'b0;
		if (mode_q) begin
			if (cmd_q == CMD_ACQUIRE) begin
				if (counter_q == '0) begin
					if (fill_q >= FILL_FULL) begin
						res_d = OUT_QUEUE_FULL;
					end else begin
						res_d  = OUT_BLOCKED;
						push   = 1'b1;
						fill_d = fill_q + 1'b1;
					end
				end else begin
					res_d     = OUT_ACQUIRED;
					counter_d = counter_q - 1'b1;
				end
			end else if (counter_q == COUNT_MAX) begin
				res_d = OUT_SATURATED;
			end else begin
				res_d     = OUT_INCREMENTED;
				counter_d = counter_q + 1'b1;
			end
		end
	end

	// wait store
	always_ff @(posedge clk) begin
		if (cmd.commit && push)
			store_mem[tail_q] <= tid_q;
		if (cmd.rd_issue)
			rdata_q <= store_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= '0;
			counter_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
		end else begin
			if (cfg.wr) begin
				init_q    <= cfg.data;
				counter_q <= cfg.data;
			end else if (cmd.commit) begin
				counter_q <= counter_d;
			end
			if (cmd.commit) begin
				fill_q <= fill_d;
				if (push)
					tail_q <= next_slot(tail_q);
			end else if (cmd.rd_issue) begin
				fill_q <= fill_q - 1'b1;
				head_q <= next_slot(head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q  <= item_command;
			tid_q  <= item_thread_id;
			mode_q <= item_thread_mode;
		end
		if (cmd.commit) begin
			outcome_q  <= res_d;
			affected_q <= push ? tid_q : '0;
			switch_q   <= push;
			count_q    <= counter_d;
			waiting_q  <= WAIT_W'(fill_d);
		end else if (cmd.wake_out) begin
			outcome_q  <= OUT_WOKE;
			affected_q <= rdata_q;
			switch_q   <= 1'b1;
			count_q    <= counter_q;
			waiting_q  <= WAIT_W'(fill_q);
		end
	end

	assign init_count      = init_q;
	assign outcome         = outcome_q;
	assign affected_thread = affected_q;
	assign switch_request  = switch_q;
	assign count_now       = count_q;
	assign waiting_now     = waiting_q;

endmodule

### rtl/core/counting_semaphore_fifo_wait.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_wait
// counting semaphore with a first-in first-out queue of blocked thread ids
// ----------------------------------------------------------------------------
// the result register is written when the output slot is free; a wake-up first
// passes through the registered read of the wait store
// the sequencer takes no new item until it is done with the last one
// reset: counter, initial count, queue pointers and fill cleared, no clearing pass
// the next item is taken while a result still waits on the output register
module counting_semaphore_fifo_wait (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csf_pkg::ADDR_W-1:0]  paddr,
	input  logic [csf_pkg::DATA_W-1:0]  pwdata,
	output logic [csf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	csf_in_if.sink                      items,
	csf_out_if.source                   results
);
	import csf_pkg::*;

	dp_cmd_t            cmd;
	dp_status_t         status;
	cfg_wr_t            cfg;
	logic [COUNT_W-1:0] init_count;
	outcome_t           outcome;

	assign pready   = 1'b1;
	assign cfg.wr   = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_INITIAL_COUNT);
	assign cfg.data = pwdata[COUNT_W-1:0];
	assign prdata   = (paddr[ADDR_W-1] == REG_INITIAL_COUNT)
		? {{(DATA_W-COUNT_W){1'b0}}, init_count} : '0;

	csf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	csf_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg              (cfg),
		.init_count       (init_count),
		.item_command     (items.command),
		.item_thread_id   (items.thread_id),
		.item_thread_mode (items.in_thread_mode),
		.outcome          (outcome),
		.affected_thread  (results.affected_thread),
		.switch_request   (results.switch_request),
		.count_now        (results.count_now),
		.waiting_now      (results.waiting_now)
	);

	assign results.outcome = outcome;

endmodule
